// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the texel coordinate RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds on every rising clock edge outside reset.
`define RCCOL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define RCCOL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rccol_pkg.sv -----
// Types and constants of the raycast column texel coordinate unit.
package rccol_pkg;

  localparam int unsigned SCREEN_HEIGHT = 512;
  localparam int unsigned TEX_SIZE      = 64;

  localparam int unsigned DIST_NW = 26;
  localparam int unsigned DIST_DW = 10;
  localparam int unsigned V_NW    = 26;
  localparam int unsigned V_DW    = 14;
  localparam int unsigned W_NW    = 42;
  localparam int unsigned W_DW    = 24;

  localparam logic [2:0] TEX_FLOOR = 3'd4;
  localparam logic [2:0] TEX_CEIL  = 3'd5;

  localparam logic REG_PLAYER_DISTANCE = 1'b0;

  typedef struct packed {
    logic [9:0]  col;
    logic [8:0]  row;
    logic [2:0]  tn;
    logic        fault;
    logic        wall;
    logic [5:0]  u_wall;
    logic        floor_row;
    logic        d_neg;
    logic        den_neg;
    logic [23:0] den_mag;
    logic [21:0] hx;
    logic [21:0] hy;
    logic [21:0] px;
    logic [21:0] py;
  } a_pay_t;

  typedef struct packed {
    logic [9:0]  col;
    logic [8:0]  row;
    logic [2:0]  tn;
    logic        fault;
    logic        wall;
    logic [5:0]  u_wall;
    logic [5:0]  v_wall;
    logic        w_neg;
    logic [21:0] hx;
    logic [21:0] hy;
    logic [21:0] px;
    logic [21:0] py;
  } b_pay_t;

endpackage

// ----- rtl/rccol_if.sv -----
// Pixel input and texel output channel interfaces.
interface rccol_in_if;
  logic        valid;
  logic        ready;
  logic [9:0]  screen_column;
  logic [8:0]  screen_row;
  logic [8:0]  draw_start;
  logic [9:0]  draw_end;
  logic [11:0] line_height;
  logic [5:0]  wall_tex_column;
  logic [1:0]  wall_texture;
  logic [21:0] wall_hit_x;
  logic [21:0] wall_hit_y;
  logic [23:0] wall_distance;
  logic [21:0] player_x;
  logic [21:0] player_y;

  modport source (output valid, screen_column, screen_row, draw_start, draw_end,
                  line_height, wall_tex_column, wall_texture, wall_hit_x, wall_hit_y,
                  wall_distance, player_x, player_y, input ready);
  modport sink (input valid, screen_column, screen_row, draw_start, draw_end,
                line_height, wall_tex_column, wall_texture, wall_hit_x, wall_hit_y,
                wall_distance, player_x, player_y, output ready);
endinterface

interface rccol_out_if;
  logic       valid;
  logic       ready;
  logic [9:0] out_column;
  logic [8:0] out_row;
  logic [2:0] texture_number;
  logic [5:0] texel_u;
  logic [5:0] texel_v;
  logic       visible;
  logic       divide_fault;

  modport source (output valid, out_column, out_row, texture_number, texel_u, texel_v,
                  visible, divide_fault, input ready);
  modport sink (input valid, out_column, out_row, texture_number, texel_u, texel_v,
                visible, divide_fault, output ready);
endinterface

// ----- rtl/rccol_div_cell.sv -----
// One restoring divide step with its pipeline register.
module rccol_div_cell #(
  parameter int unsigned NW = 26,
  parameter int unsigned DW = 10,
  parameter int unsigned PW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [DW-1:0] rem_i,
  input  logic [NW-1:0] nq_i,
  input  logic [DW-1:0] div_i,
  input  logic [PW-1:0] pay_i,
  output logic          valid_o,
  output logic [DW-1:0] rem_o,
  output logic [NW-1:0] nq_o,
  output logic [DW-1:0] div_o,
  output logic [PW-1:0] pay_o
);

  logic          valid_q;
  logic [DW-1:0] rem_d, rem_q;
  logic [NW-1:0] nq_d, nq_q;
  logic [DW-1:0] div_q;
  logic [PW-1:0] pay_q;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  always_comb begin
    trial = {rem_i, nq_i[NW-1]};
    diff  = trial - {1'b0, div_i};
    ge    = trial >= {1'b0, div_i};
    rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
    nq_d  = {nq_i[NW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      nq_q  <= nq_d;
      div_q <= div_i;
      pay_q <= pay_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign nq_o    = nq_q;
  assign div_o   = div_q;
  assign pay_o   = pay_q;

endmodule

// ----- rtl/rccol_div_chain.sv -----
// Row of divide cells: one quotient bit per cell, payload rides alongside.
module rccol_div_chain #(
  parameter int unsigned NW = 26,
  parameter int unsigned DW = 10,
  parameter int unsigned PW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] div_i,
  input  logic [PW-1:0] pay_i,
  output logic          valid_o,
  output logic [NW-1:0] quo_o,
  output logic [PW-1:0] pay_o
);

  logic          vld [NW+1];
  logic [DW-1:0] rem [NW+1];
  logic [NW-1:0] nq  [NW+1];
  logic [DW-1:0] dv  [NW+1];
  logic [PW-1:0] pay [NW+1];

  assign vld[0] = valid_i;
  assign rem[0] = '0;
  assign nq[0]  = num_i;
  assign dv[0]  = div_i;
  assign pay[0] = pay_i;

  for (genvar i = 0; i < NW; i++) begin : g_cell
    rccol_div_cell #(.NW(NW), .DW(DW), .PW(PW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_i),
      .valid_i (vld[i]),
      .rem_i   (rem[i]),
      .nq_i    (nq[i]),
      .div_i   (dv[i]),
      .pay_i   (pay[i]),
      .valid_o (vld[i+1]),
      .rem_o   (rem[i+1]),
      .nq_o    (nq[i+1]),
      .div_o   (dv[i+1]),
      .pay_o   (pay[i+1])
    );
  end

  assign valid_o = vld[NW];
  assign quo_o   = nq[NW];
  assign pay_o   = pay[NW];

endmodule

// ----- rtl/raycast_column_texel_coords.sv -----
// Raycast column texel coordinates: one pixel in and one texel address out per clock, in
// order, from input beat to output register through parallel rows of 26 cells for the floor
// distance and wall v divides, 42 cells for the interpolation weight divide, and four plain
// stages. Throughput is one beat per cycle; the whole pipe holds while a finished beat waits
// at the output. player_distance is written over APB at byte address 0 and must only change
// while no beat is in flight.
`include "assert_macros.svh"

module raycast_column_texel_coords (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  rccol_in_if.sink    in_i,
  rccol_out_if.source out_o
);

  logic [23:0] pd_q;
  logic        pd_wr;
  logic        en;
  logic        out_vld_q;

  // ---------------- configuration ----------------
  assign pd_wr = psel && penable && pwrite && pready
                 && (paddr[2] == rccol_pkg::REG_PLAYER_DISTANCE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pd_q <= '0;
    end else if (pd_wr) begin
      pd_q <= pwdata[23:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == rccol_pkg::REG_PLAYER_DISTANCE) ? {8'd0, pd_q} : 32'd0;

  // Advance the whole pipe unless the output holds a beat nobody takes.
  assign en         = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  // ---------------- entry decode ----------------
  logic               floor_row, ceil_row, wall;
  logic [11:0]        d;
  logic               d_neg;
  logic [11:0]        d_abs;
  logic [24:0]        den;
  logic [24:0]        den_abs;
  logic [20:0]        k;
  logic [25:0]        k_num;
  rccol_pkg::a_pay_t  a_in;

  always_comb begin
    floor_row = {1'b0, in_i.screen_row} >= in_i.draw_end;
    ceil_row  = !floor_row && (in_i.screen_row < in_i.draw_start);
    wall      = !floor_row && !ceil_row;
    d         = {2'b00, in_i.screen_row, 1'b0} - 12'(rccol_pkg::SCREEN_HEIGHT);
    d_neg     = d[11];
    d_abs     = d_neg ? (12'd0 - d) : d;
    den       = {1'b0, in_i.wall_distance} - {1'b0, pd_q};
    den_abs   = den[24] ? (25'd0 - den) : den;
    k         = {4'd0, in_i.screen_row, 8'd0} + {2'd0, in_i.line_height, 7'd0}
                - 21'd65536;
    k_num     = k[20] ? 26'd0 : {6'd0, k[19:0]};

    a_in.col       = in_i.screen_column;
    a_in.row       = in_i.screen_row;
    a_in.tn        = wall ? {1'b0, in_i.wall_texture}
                          : (floor_row ? rccol_pkg::TEX_FLOOR : rccol_pkg::TEX_CEIL);
    a_in.fault     = wall ? (in_i.line_height == 12'd0)
                          : ((d == 12'd0) || (in_i.wall_distance == pd_q));
    a_in.wall      = wall;
    a_in.u_wall    = in_i.wall_tex_column;
    a_in.floor_row = floor_row;
    a_in.d_neg     = d_neg;
    a_in.den_neg   = den[24];
    a_in.den_mag   = den_abs[23:0];
    a_in.hx        = in_i.wall_hit_x;
    a_in.hy        = in_i.wall_hit_y;
    a_in.px        = in_i.player_x;
    a_in.py        = in_i.player_y;
  end

  // ---------------- floor distance and wall v divides ----------------
  logic                         a_vld;
  logic [rccol_pkg::DIST_NW-1:0] dist_q;
  rccol_pkg::a_pay_t            a_out;
  logic                         v_vld;
  logic [rccol_pkg::V_NW-1:0]   v_quo;
  logic                         v_wall_flag;

  rccol_div_chain #(
    .NW(rccol_pkg::DIST_NW), .DW(rccol_pkg::DIST_DW), .PW($bits(rccol_pkg::a_pay_t))
  ) u_dist_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .num_i   (rccol_pkg::DIST_NW'(rccol_pkg::SCREEN_HEIGHT) << 16),
    .div_i   (d_abs[rccol_pkg::DIST_DW-1:0]),
    .pay_i   (a_in),
    .valid_o (a_vld),
    .quo_o   (dist_q),
    .pay_o   (a_out)
  );

  rccol_div_chain #(
    .NW(rccol_pkg::V_NW), .DW(rccol_pkg::V_DW), .PW(1)
  ) u_v_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .num_i   (k_num),
    .div_i   ({in_i.line_height, 2'b00}),
    .pay_i   (wall),
    .valid_o (v_vld),
    .quo_o   (v_quo),
    .pay_o   (v_wall_flag)
  );

  // ---------------- weight numerator ----------------
  logic [26:0]       dist_s, num;
  logic [26:0]       num_abs;
  rccol_pkg::b_pay_t b_d;
  logic              m1_vld_q;
  logic [25:0]       m1_num_q;
  logic [23:0]       m1_den_q;
  rccol_pkg::b_pay_t m1_pay_q;

  always_comb begin
    dist_s  = a_out.d_neg ? (27'd0 - {1'b0, dist_q}) : {1'b0, dist_q};
    num     = a_out.floor_row ? (dist_s - {3'd0, pd_q}) : ({3'd0, pd_q} - dist_s);
    num_abs = num[26] ? (27'd0 - num) : num;

    b_d.col    = a_out.col;
    b_d.row    = a_out.row;
    b_d.tn     = a_out.tn;
    b_d.fault  = a_out.fault;
    b_d.wall   = v_wall_flag;
    b_d.u_wall = a_out.u_wall;
    b_d.v_wall = (|v_quo[rccol_pkg::V_NW-1:6]) ? 6'(rccol_pkg::TEX_SIZE - 1) : v_quo[5:0];
    b_d.w_neg  = num[26] ^ a_out.den_neg;
    b_d.hx     = a_out.hx;
    b_d.hy     = a_out.hy;
    b_d.px     = a_out.px;
    b_d.py     = a_out.py;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_vld_q <= 1'b0;
    end else if (en) begin
      m1_vld_q <= a_vld && v_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_num_q <= num_abs[25:0];
      m1_den_q <= a_out.den_mag;
      m1_pay_q <= b_d;
    end
  end

  // ---------------- weight divide ----------------
  logic                       b_vld;
  logic [rccol_pkg::W_NW-1:0] w_quo;
  rccol_pkg::b_pay_t          b_out;

  rccol_div_chain #(
    .NW(rccol_pkg::W_NW), .DW(rccol_pkg::W_DW), .PW($bits(rccol_pkg::b_pay_t))
  ) u_w_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (m1_vld_q),
    .num_i   ({m1_num_q, 16'd0}),
    .div_i   (m1_den_q),
    .pay_i   (m1_pay_q),
    .valid_o (b_vld),
    .quo_o   (w_quo),
    .pay_o   (b_out)
  );

  // ---------------- saturate weight, form deltas ----------------
  logic [29:0]       w_mag;
  logic [30:0]       w_d;
  logic              m2_vld_q;
  logic [30:0]       m2_w_q;
  logic [22:0]       m2_dx_q, m2_dy_q;
  rccol_pkg::b_pay_t m2_pay_q;

  always_comb begin
    w_mag = (|w_quo[rccol_pkg::W_NW-1:30]) ? 30'h3fffffff : w_quo[29:0];
    w_d   = b_out.w_neg ? (31'd0 - {1'b0, w_mag}) : {1'b0, w_mag};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_vld_q <= 1'b0;
    end else if (en) begin
      m2_vld_q <= b_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m2_w_q   <= w_d;
      m2_dx_q  <= {1'b0, b_out.hx} - {1'b0, b_out.px};
      m2_dy_q  <= {1'b0, b_out.hy} - {1'b0, b_out.py};
      m2_pay_q <= b_out;
    end
  end

  // ---------------- weight times delta ----------------
  logic [53:0]       prod_x, prod_y;
  logic              m3_vld_q;
  logic [31:0]       m3_px_q, m3_py_q;
  rccol_pkg::b_pay_t m3_pay_q;

  // Both operands sign-extend to the full product width.
  assign prod_x = $signed(m2_w_q) * $signed(m2_dx_q);
  assign prod_y = $signed(m2_w_q) * $signed(m2_dy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m3_vld_q <= 1'b0;
    end else if (en) begin
      m3_vld_q <= m2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m3_px_q  <= prod_x[31:0];
      m3_py_q  <= prod_y[31:0];
      m3_pay_q <= m2_pay_q;
    end
  end

  // ---------------- coordinate and output register ----------------
  logic [31:0] cx, cy;
  logic [5:0]  u_d, v_d;
  logic [9:0]  out_col_q;
  logic [8:0]  out_row_q;
  logic [2:0]  out_tn_q;
  logic [5:0]  out_u_q, out_v_q;
  logic        out_fault_q;
  logic        out_texel_nz;

  // Only the low 32 bits of the Q.32 coordinate reach the texel index.
  always_comb begin
    cx = {m3_pay_q.px[15:0], 16'd0} + m3_px_q;
    cy = {m3_pay_q.py[15:0], 16'd0} + m3_py_q;
    if (m3_pay_q.fault) begin
      u_d = 6'd0;
      v_d = 6'd0;
    end else if (m3_pay_q.wall) begin
      u_d = m3_pay_q.u_wall;
      v_d = m3_pay_q.v_wall;
    end else begin
      u_d = cx[31:26];
      v_d = cy[31:26];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= m3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_col_q   <= m3_pay_q.col;
      out_row_q   <= m3_pay_q.row;
      out_tn_q    <= m3_pay_q.tn;
      out_u_q     <= u_d;
      out_v_q     <= v_d;
      out_fault_q <= m3_pay_q.fault;
    end
  end

  assign out_texel_nz = |{out_u_q, out_v_q};

  assign out_o.valid          = out_vld_q;
  assign out_o.out_column     = out_col_q;
  assign out_o.out_row        = out_row_q;
  assign out_o.texture_number = out_tn_q;
  assign out_o.texel_u        = out_u_q;
  assign out_o.texel_v        = out_v_q;
  assign out_o.visible        = 1'b1;
  assign out_o.divide_fault   = out_fault_q;

  // ---------------- checks ----------------
  `RCCOL_ASSERT(a_fault_zero, !(out_vld_q && out_fault_q && out_texel_nz), "fault with texel")
  `RCCOL_ASSERT(a_w_sat, !m2_vld_q || m2_w_q != 31'h40000000, "weight escaped saturation")
  `RCCOL_ASSERT_NEXT(a_cfg_write, pd_wr, pd_q == $past(pwdata[23:0]), "player distance lost")
  `RCCOL_ASSERT(a_lanes_aligned, a_vld == v_vld, "divide rows out of step")

endmodule

// ----- bench/tb.sv -----
// Testbench for raycast_column_texel_coords: random and directed pixels against a predictor.
`timescale 1ns / 100ps

module tb;

  localparam int SCR_H = 512;
  localparam int SCR_W = 1024;
  localparam int TEX = 64;
  localparam longint W_SAT = 64'd1073741823;
  localparam logic [2:0] ADDR_PLAYER_DIST = {rccol_pkg::REG_PLAYER_DISTANCE, 2'b00};
  localparam int PIPE_LAT = 80;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [9:0]  col;
    logic [8:0]  row;
    logic [2:0]  tn;
    logic [5:0]  u;
    logic [5:0]  v;
    logic        vis;
    logic        fault;
  } texel_t;

  typedef struct {
    logic [9:0]  col;
    logic [8:0]  row;
    logic [8:0]  ds;
    logic [9:0]  de;
    logic [11:0] lh;
    logic [5:0]  tcol;
    logic [1:0]  tw;
    logic [21:0] hx;
    logic [21:0] hy;
    logic [23:0] wd;
    logic [21:0] px;
    logic [21:0] py;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  rccol_in_if in_ch();
  rccol_out_if out_ch();

  raycast_column_texel_coords DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_i(in_ch.sink), .out_o(out_ch.source)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  logic [23:0] player_dist = '0;
  texel_t expected_texels[$];
  int errors = 0;
  int checked = 0;
  int faults_seen = 0;
  int sink_hold = 0;
  bit sink_idle_on = 1'b1;
  bit src_idle_on = 1'b1;
  longint cycles = 0;

  initial begin
    in_ch.valid = 1'b0;
    {in_ch.screen_column, in_ch.screen_row, in_ch.draw_start, in_ch.draw_end} = '0;
    {in_ch.line_height, in_ch.wall_tex_column, in_ch.wall_texture} = '0;
    {in_ch.wall_hit_x, in_ch.wall_hit_y, in_ch.wall_distance} = '0;
    {in_ch.player_x, in_ch.player_y} = '0;
    out_ch.ready = 1'b0;
  end

  function automatic longint div_trunc(longint n, longint d);
    longint nm, dm, q;
    nm = (n < 0) ? -n : n;
    dm = (d < 0) ? -d : d;
    q = nm / dm;
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  // Interpolate hit vs player in Q.32, scale to texels, floor and wrap.
  function automatic logic [5:0] blend_texel(longint w, longint hit, longint pos);
    longint c, f, m;
    c = (pos * 65536 + w * (hit - pos)) * TEX;
    f = c >>> 32;
    m = f % TEX;
    if (m < 0) m += TEX;
    return m[5:0];
  endfunction

  function automatic texel_t texel_of(pixel_t p);
    texel_t r;
    longint d, den, fdist, num, w, k, v;
    bit floor_row;
    r.col = p.col;
    r.row = p.row;
    r.u = '0;
    r.v = '0;
    r.fault = 1'b0;
    r.vis = (p.col < SCR_W) && (p.row < SCR_H);
    if (p.row >= p.de || p.row < p.ds) begin
      floor_row = (p.row >= p.de);
      r.tn = floor_row ? rccol_pkg::TEX_FLOOR : rccol_pkg::TEX_CEIL;
      d = 2 * longint'(p.row) - SCR_H;
      den = longint'(p.wd) - longint'(player_dist);
      if (d == 0 || den == 0) begin
        r.fault = 1'b1;
      end else begin
        fdist = div_trunc(longint'(SCR_H) * 65536, d);
        num = floor_row ? fdist - longint'(player_dist) : longint'(player_dist) - fdist;
        w = div_trunc(num * 65536, den);
        if (w > W_SAT) w = W_SAT;
        if (w < -W_SAT) w = -W_SAT;
        r.u = blend_texel(w, p.hx, p.px);
        r.v = blend_texel(w, p.hy, p.py);
      end
    end else begin
      r.tn = {1'b0, p.tw};
      if (p.lh == 0) begin
        r.fault = 1'b1;
      end else begin
        k = longint'(p.row) * 256 - SCR_H * 128 + longint'(p.lh) * 128;
        r.u = p.tcol;
        if (k < 0) begin
          v = 0;
        end else begin
          v = ((k * TEX) / p.lh) / 256;
          if (v >= TEX) v = TEX - 1;
        end
        r.v = v[5:0];
      end
    end
    return r;
  endfunction

  task automatic idle_burst();
    repeat ($urandom_range(18, 1)) @(posedge clk_i);
  endtask

  // Valid stays high between beats; drop it only for an idle burst or a drain.
  task automatic send_pixel(pixel_t p);
    if (src_idle_on && $urandom_range(5, 0) == 0) begin
      in_ch.valid <= 1'b0;
      idle_burst();
    end
    in_ch.valid <= 1'b1;
    in_ch.screen_column <= p.col;
    in_ch.screen_row <= p.row;
    in_ch.draw_start <= p.ds;
    in_ch.draw_end <= p.de;
    in_ch.line_height <= p.lh;
    in_ch.wall_tex_column <= p.tcol;
    in_ch.wall_texture <= p.tw;
    in_ch.wall_hit_x <= p.hx;
    in_ch.wall_hit_y <= p.hy;
    in_ch.wall_distance <= p.wd;
    in_ch.player_x <= p.px;
    in_ch.player_y <= p.py;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    expected_texels.push_back(texel_of(p));
  endtask

  task automatic write_player_dist(logic [23:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_PLAYER_DIST;
    pwdata <= {8'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    player_dist = val;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_texels.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT) @(posedge clk_i);
  endtask

  // Sink side: random stalls, check each beat against the oldest prediction.
  always @(posedge clk_i) begin
    texel_t got, want;
    if (rst_ni) begin
      cycles <= cycles + 1;
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.out_column, out_ch.out_row, out_ch.texture_number, out_ch.texel_u,
               out_ch.texel_v, out_ch.visible, out_ch.divide_fault};
        if (expected_texels.size() == 0) begin
          $display("%0t: unexpected texel beat %h", $time, got);
          errors++;
        end else begin
          want = expected_texels.pop_front();
          checked++;
          if (got.fault) faults_seen++;
          if (got !== want) begin
            $display("%0t: mismatch expected col=%0d row=%0d tn=%0d u=%0d v=%0d vis=%0b f=%0b",
                     $time, want.col, want.row, want.tn, want.u, want.v, want.vis, want.fault);
            $display("%0t:          actual col=%0d row=%0d tn=%0d u=%0d v=%0d vis=%0b f=%0b",
                     $time, got.col, got.row, got.tn, got.u, got.v, got.vis, got.fault);
            errors++;
          end
        end
      end
      if (sink_idle_on && sink_hold > 0) begin
        out_ch.ready <= 1'b0;
        sink_hold <= sink_hold - 1;
      end else if (sink_idle_on && $urandom_range(7, 0) == 0) begin
        out_ch.ready <= 1'b0;
        sink_hold <= int'($urandom_range(17, 0));
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: FAIL");
      $finish;
    end
  end

  function automatic pixel_t random_pixel();
    pixel_t p;
    int ds, lh;
    lh = ($urandom_range(9, 0) == 0) ? int'($urandom_range(4095, 0))
                                     : int'($urandom_range(600, 1));
    ds = int'($urandom_range(300, 0));
    p.col = 10'($urandom_range(1023, 0));
    p.row = 9'($urandom_range(511, 0));
    p.ds = 9'(ds);
    p.de = ($urandom_range(9, 0) == 0) ? 10'($urandom_range(1023, 0))
                                       : 10'(ds + int'($urandom_range(212, 0)));
    p.lh = 12'(lh);
    p.tcol = 6'($urandom);
    p.tw = 2'($urandom);
    p.hx = 22'($urandom);
    p.hy = 22'($urandom);
    p.wd = 24'($urandom);
    p.px = 22'($urandom);
    p.py = 22'($urandom);
    if ($urandom_range(19, 0) == 0) p.wd = player_dist;
    if ($urandom_range(29, 0) == 0) p.row = 9'(SCR_H / 2);
    return p;
  endfunction

  task automatic test_directed();
    pixel_t base, p;
    base = '{col: 10'd5, row: 9'd100, ds: 9'd50, de: 10'd300, lh: 12'd250, tcol: 6'd17,
             tw: 2'd2, hx: 22'h0A0000, hy: 22'h050000, wd: 24'h030000,
             px: 22'h020000, py: 22'h040000};
    send_pixel(base);                                        // wall
    p = base; p.row = 9'd10; send_pixel(p);                  // ceiling
    p = base; p.row = 9'd511; send_pixel(p);                 // floor, bottom row
    p = base; p.row = 9'd256; p.ds = 9'd300; send_pixel(p);  // mid-screen divisor zero
    p = base; p.lh = 12'd0; send_pixel(p);                   // zero line height
    p = base; p.wd = player_dist; p.row = 9'd400; send_pixel(p);
    p = base; p.row = 9'd60; p.lh = 12'd1; send_pixel(p);    // negative k
    p = base; p.row = 9'd299; p.lh = 12'd20; send_pixel(p);  // v past texture
    p = base; p.ds = 9'd200; p.de = 10'd100; p.row = 9'd150; send_pixel(p); // end before start
    p = base; p.col = 10'd1023; p.row = 9'd0; p.ds = 9'd0; p.de = 10'd512;
    p.lh = 12'd4095; p.tcol = 6'd63; p.tw = 2'd3; send_pixel(p);
    p = base; p.ds = 9'd511; p.de = 10'd0; p.hx = '1; p.hy = '1; p.px = '0; p.py = '0;
    p.wd = '1; send_pixel(p);
    p.row = 9'd0; p.hx = '0; p.hy = '0; p.px = '1; p.py = '1; p.wd = 24'd1; send_pixel(p);
    p.de = 10'd1023; p.row = 9'd1; send_pixel(p);            // ceiling down to row 510
  endtask

  task automatic test_random(int n);
    repeat (n) send_pixel(random_pixel());
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    drain();
    write_player_dist(24'hFFFFFF);
    test_directed();
    test_random(250);
    drain();
    write_player_dist(24'h000000);
    test_random(350);
    drain();
    write_player_dist(24'h018000);
    test_random(350);
    drain();
    write_player_dist(24'h000001);
    test_random(300);
    drain();
    write_player_dist(24'($urandom));
    // final stretch at full rate on both sides
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    test_random(274);
    drain();
    $display("checked %0d texel beats over 5 player distance settings, %0d with divide fault",
             checked, faults_seen);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/rccol_pkg.sv
rtl/rccol_if.sv
rtl/rccol_div_cell.sv
rtl/rccol_div_chain.sv
rtl/raycast_column_texel_coords.sv
bench/tb.sv
